/* design/sip_pkg.sv */
// Shared constants and types for the segment intersection pipeline.
package sip_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_CROSS     = 2'd1,
        KIND_COLLINEAR = 2'd2,
        KIND_POINT     = 2'd3
    } kind_t;

endpackage

/* design/segment_intersection_point.sv */
// Pipelined two-segment intersection test that reports the meeting point.
//
// Input channel (s_*): one transaction carries both segments as eight signed
// fixed-point coordinates packed in s_tdata. The binary point position does
// not change any decision, since the scale cancels in every ratio.
// Output channel (m_*): one transaction per input, in order. m_tuser holds the
// hit flag and the hit kind; m_tdata holds the meeting point, which reads zero
// when there is no hit.
// The pipeline is seven stages of difference, cross product, classification
// and scaling, one restoring divider stage per quotient bit (COORD_WIDTH + 1),
// and the output register. One transaction is accepted every cycle while the
// output is not stalled.
// Each divider stage is one wide compare and subtract; the scaling products
// are split into two half-width multiplies so no multiplier exceeds
// (COORD_WIDTH + 1) bits square.
// Reset clears the valid bits of every stage; the pipeline comes up empty.
// When the receiver stalls with a result waiting, all stages hold together
// and s_tready falls, so nothing is lost or repeated.
module segment_intersection_point #(
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_WIDTH-1:0]                s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // hit_x, hit_y, zero padding
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
    // hit, hit_kind[1:0]
    output logic [2:0]                              m_tuser
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * W + 3;
    localparam int NW = 2 * DW;
    localparam int MW = 3 * DW;
    localparam int QW = DW;
    localparam int OW = ((2 * W + 7) / 8) * 8;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage A: differences and bounding box ----------------
    logic signed [W-1:0] ix1, iy1, ix2, iy2, ix3, iy3, ix4, iy4;
    assign ix1 = s_tdata[0*W +: W];
    assign iy1 = s_tdata[1*W +: W];
    assign ix2 = s_tdata[2*W +: W];
    assign iy2 = s_tdata[3*W +: W];
    assign ix3 = s_tdata[4*W +: W];
    assign iy3 = s_tdata[5*W +: W];
    assign ix4 = s_tdata[6*W +: W];
    assign iy4 = s_tdata[7*W +: W];

    logic in_box_next;
    assign in_box_next = ((ix1 >= ix3 && ix1 <= ix4) || (ix1 >= ix4 && ix1 <= ix3)) &&
                         ((iy1 >= iy3 && iy1 <= iy4) || (iy1 >= iy4 && iy1 <= iy3));

    logic                 a_v_reg;
    logic signed [DW-1:0] a_dx_reg, a_dy_reg, a_ex_reg, a_ey_reg;
    logic signed [DW-1:0] a_px_reg, a_py_reg, a_qx_reg, a_qy_reg;
    logic signed [W-1:0]  a_x1_reg, a_y1_reg;
    logic                 a_box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg  <= DW'(ix2) - DW'(ix1);
            a_dy_reg  <= DW'(iy2) - DW'(iy1);
            a_ex_reg  <= DW'(ix4) - DW'(ix3);
            a_ey_reg  <= DW'(iy4) - DW'(iy3);
            a_px_reg  <= DW'(ix3) - DW'(ix1);
            a_py_reg  <= DW'(iy3) - DW'(iy1);
            a_qx_reg  <= DW'(ix4) - DW'(ix1);
            a_qy_reg  <= DW'(iy4) - DW'(iy1);
            a_x1_reg  <= ix1;
            a_y1_reg  <= iy1;
            a_box_reg <= in_box_next;
        end
    end

    // ---------------- stage B: cross and dot products ----------------
    logic                 b_v_reg;
    logic signed [PW-1:0] b_dxey_reg, b_dyex_reg, b_pxey_reg, b_pyex_reg;
    logic signed [PW-1:0] b_pxdy_reg, b_pydx_reg, b_dxdx_reg, b_dydy_reg;
    logic signed [PW-1:0] b_pxdx_reg, b_pydy_reg, b_qxdx_reg, b_qydy_reg;
    logic signed [DW-1:0] b_dx_reg, b_dy_reg;
    logic signed [W-1:0]  b_x1_reg, b_y1_reg;
    logic                 b_box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dxey_reg <= a_dx_reg * a_ey_reg;
            b_dyex_reg <= a_dy_reg * a_ex_reg;
            b_pxey_reg <= a_px_reg * a_ey_reg;
            b_pyex_reg <= a_py_reg * a_ex_reg;
            b_pxdy_reg <= a_px_reg * a_dy_reg;
            b_pydx_reg <= a_py_reg * a_dx_reg;
            b_dxdx_reg <= a_dx_reg * a_dx_reg;
            b_dydy_reg <= a_dy_reg * a_dy_reg;
            b_pxdx_reg <= a_px_reg * a_dx_reg;
            b_pydy_reg <= a_py_reg * a_dy_reg;
            b_qxdx_reg <= a_qx_reg * a_dx_reg;
            b_qydy_reg <= a_qy_reg * a_dy_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_x1_reg   <= a_x1_reg;
            b_y1_reg   <= a_y1_reg;
            b_box_reg  <= a_box_reg;
        end
    end

    // ---------------- stage C: determinant, numerators, projections ----------------
    logic                 c_v_reg;
    logic signed [SW-1:0] c_den_reg, c_nt_reg, c_nu_reg, c_len_reg, c_n3_reg, c_n4_reg;
    logic signed [DW-1:0] c_dx_reg, c_dy_reg;
    logic signed [W-1:0]  c_x1_reg, c_y1_reg;
    logic                 c_box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_den_reg <= SW'(b_dxey_reg) - SW'(b_dyex_reg);
            c_nt_reg  <= SW'(b_pxey_reg) - SW'(b_pyex_reg);
            c_nu_reg  <= SW'(b_pxdy_reg) - SW'(b_pydx_reg);
            c_len_reg <= SW'(b_dxdx_reg) + SW'(b_dydy_reg);
            c_n3_reg  <= SW'(b_pxdx_reg) + SW'(b_pydy_reg);
            c_n4_reg  <= SW'(b_qxdx_reg) + SW'(b_qydy_reg);
            c_dx_reg  <= b_dx_reg;
            c_dy_reg  <= b_dy_reg;
            c_x1_reg  <= b_x1_reg;
            c_y1_reg  <= b_y1_reg;
            c_box_reg <= b_box_reg;
        end
    end

    // ---------------- stage D: sign normalization, overlap ends ----------------
    logic                 d_v_reg;
    logic [NW-1:0]        d_dabs_reg;
    logic signed [SW-1:0] d_nt_reg, d_nu_reg, d_mn_reg, d_mx_reg, d_len_reg;
    logic                 d_dnz_reg, d_ntz_reg, d_nuz_reg;
    logic signed [DW-1:0] d_dx_reg, d_dy_reg;
    logic signed [W-1:0]  d_x1_reg, d_y1_reg;
    logic                 d_box_reg;

    logic                 den_neg;
    logic signed [SW-1:0] den_abs_full;
    assign den_neg      = c_den_reg[SW-1];
    assign den_abs_full = den_neg ? -c_den_reg : c_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_dabs_reg <= den_abs_full[NW-1:0];
            d_nt_reg   <= den_neg ? -c_nt_reg : c_nt_reg;
            d_nu_reg   <= den_neg ? -c_nu_reg : c_nu_reg;
            d_mn_reg   <= (c_n3_reg <= c_n4_reg) ? c_n3_reg : c_n4_reg;
            d_mx_reg   <= (c_n3_reg <= c_n4_reg) ? c_n4_reg : c_n3_reg;
            d_len_reg  <= c_len_reg;
            d_dnz_reg  <= (c_den_reg != '0);
            d_ntz_reg  <= (c_nt_reg == '0);
            d_nuz_reg  <= (c_nu_reg == '0);
            d_dx_reg   <= c_dx_reg;
            d_dy_reg   <= c_dy_reg;
            d_x1_reg   <= c_x1_reg;
            d_y1_reg   <= c_y1_reg;
            d_box_reg  <= c_box_reg;
        end
    end

    // ---------------- stage E: classification, ratio selection ----------------
    sip_pkg::kind_t kind_next;
    logic [NW-1:0]  num_next, dvs_next;
    logic           cross_ok, coll_ok;
    logic           cross_ok_t, cross_ok_u;

    assign cross_ok_t = !d_nt_reg[SW-1] && (d_nt_reg <= $signed({1'b0, d_dabs_reg}));
    assign cross_ok_u = !d_nu_reg[SW-1] && (d_nu_reg <= $signed({1'b0, d_dabs_reg}));
    assign cross_ok   = cross_ok_t && cross_ok_u;
    // The clamped overlap is nonempty when the projected span meets segment A's
    // parameter range: its low end is at most len and its high end is not negative.
    assign coll_ok    = (d_mn_reg <= d_len_reg) && !d_mx_reg[SW-1];

    always_comb
    begin
        kind_next = sip_pkg::KIND_NONE;
        num_next  = '0;
        dvs_next  = NW'(1);
        if (d_dnz_reg)
        begin
            if (cross_ok)
            begin
                kind_next = sip_pkg::KIND_CROSS;
                num_next  = d_nt_reg[NW-1:0];
                dvs_next  = d_dabs_reg;
            end
        end
        else if (d_ntz_reg && d_nuz_reg)
        begin
            if (d_len_reg == '0)
            begin
                if (d_box_reg)
                begin
                    kind_next = sip_pkg::KIND_POINT;
                end
            end
            else if (coll_ok)
            begin
                kind_next = sip_pkg::KIND_COLLINEAR;
                num_next  = d_mn_reg[SW-1] ? '0 : d_mn_reg[NW-1:0];
                dvs_next  = d_len_reg[NW-1:0];
            end
        end
    end

    logic           e_v_reg;
    sip_pkg::kind_t e_kind_reg;
    logic [NW-1:0]  e_num_reg, e_dvs_reg;
    logic [DW-1:0]  e_ax_reg, e_ay_reg;
    logic           e_sx_reg, e_sy_reg;
    logic signed [W-1:0] e_x1_reg, e_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_kind_reg <= kind_next;
            e_num_reg  <= num_next;
            e_dvs_reg  <= dvs_next;
            e_ax_reg   <= d_dx_reg[DW-1] ? DW'(-d_dx_reg) : DW'(d_dx_reg);
            e_ay_reg   <= d_dy_reg[DW-1] ? DW'(-d_dy_reg) : DW'(d_dy_reg);
            e_sx_reg   <= d_dx_reg[DW-1];
            e_sy_reg   <= d_dy_reg[DW-1];
            e_x1_reg   <= d_x1_reg;
            e_y1_reg   <= d_y1_reg;
        end
    end

    // ---------------- stage F: half-width partial products ----------------
    logic           f_v_reg;
    sip_pkg::kind_t f_kind_reg;
    logic [PW-1:0]  f_xlo_reg, f_xhi_reg, f_ylo_reg, f_yhi_reg;
    logic [NW-1:0]  f_dvs_reg;
    logic           f_sx_reg, f_sy_reg;
    logic signed [W-1:0] f_x1_reg, f_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_xlo_reg  <= PW'(e_num_reg[DW-1:0])  * PW'(e_ax_reg);
            f_xhi_reg  <= PW'(e_num_reg[NW-1:DW]) * PW'(e_ax_reg);
            f_ylo_reg  <= PW'(e_num_reg[DW-1:0])  * PW'(e_ay_reg);
            f_yhi_reg  <= PW'(e_num_reg[NW-1:DW]) * PW'(e_ay_reg);
            f_kind_reg <= e_kind_reg;
            f_dvs_reg  <= e_dvs_reg;
            f_sx_reg   <= e_sx_reg;
            f_sy_reg   <= e_sy_reg;
            f_x1_reg   <= e_x1_reg;
            f_y1_reg   <= e_y1_reg;
        end
    end

    // ---------------- stage G and divider pipeline ----------------
    // Index 0 holds the full dividends; each following stage settles one
    // quotient bit, most significant first.
    logic           dv_v_reg    [0:QW];
    sip_pkg::kind_t dv_kind_reg [0:QW];
    logic [MW-1:0]  dv_rx_reg   [0:QW];
    logic [MW-1:0]  dv_ry_reg   [0:QW];
    logic [QW-1:0]  dv_qx_reg   [0:QW];
    logic [QW-1:0]  dv_qy_reg   [0:QW];
    logic [NW-1:0]  dv_dvs_reg  [0:QW];
    logic           dv_sx_reg   [0:QW];
    logic           dv_sy_reg   [0:QW];
    logic signed [W-1:0] dv_x1_reg [0:QW];
    logic signed [W-1:0] dv_y1_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rx_reg[0]   <= MW'(f_xlo_reg) + (MW'(f_xhi_reg) << DW);
            dv_ry_reg[0]   <= MW'(f_ylo_reg) + (MW'(f_yhi_reg) << DW);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            dv_kind_reg[0] <= f_kind_reg;
            dv_dvs_reg[0]  <= f_dvs_reg;
            dv_sx_reg[0]   <= f_sx_reg;
            dv_sy_reg[0]   <= f_sy_reg;
            dv_x1_reg[0]   <= f_x1_reg;
            dv_y1_reg[0]   <= f_y1_reg;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [MW-1:0] dsh;
        logic          gex, gey;
        assign dsh = MW'(dv_dvs_reg[k]) << (QW - 1 - k);
        assign gex = dv_rx_reg[k] >= dsh;
        assign gey = dv_ry_reg[k] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rx_reg[k+1]   <= gex ? dv_rx_reg[k] - dsh : dv_rx_reg[k];
                dv_ry_reg[k+1]   <= gey ? dv_ry_reg[k] - dsh : dv_ry_reg[k];
                dv_qx_reg[k+1]   <= dv_qx_reg[k] | (gex ? QW'(1) << (QW - 1 - k) : '0);
                dv_qy_reg[k+1]   <= dv_qy_reg[k] | (gey ? QW'(1) << (QW - 1 - k) : '0);
                dv_kind_reg[k+1] <= dv_kind_reg[k];
                dv_dvs_reg[k+1]  <= dv_dvs_reg[k];
                dv_sx_reg[k+1]   <= dv_sx_reg[k];
                dv_sy_reg[k+1]   <= dv_sy_reg[k];
                dv_x1_reg[k+1]   <= dv_x1_reg[k];
                dv_y1_reg[k+1]   <= dv_y1_reg[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [DW:0]  offx, offy;
    logic signed [W+1:0] sumx, sumy;
    logic                hit_next;

    assign offx = dv_sx_reg[QW] ? -$signed({1'b0, dv_qx_reg[QW]}) : $signed({1'b0, dv_qx_reg[QW]});
    assign offy = dv_sy_reg[QW] ? -$signed({1'b0, dv_qy_reg[QW]}) : $signed({1'b0, dv_qy_reg[QW]});
    assign sumx = (W+2)'(dv_x1_reg[QW]) + (W+2)'(offx);
    assign sumy = (W+2)'(dv_y1_reg[QW]) + (W+2)'(offy);
    assign hit_next = (dv_kind_reg[QW] != sip_pkg::KIND_NONE);

    logic           out_v_reg;
    sip_pkg::kind_t out_kind_reg;
    logic           out_hit_reg;
    logic [W-1:0]   out_x_reg, out_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_kind_reg <= dv_kind_reg[QW];
            out_hit_reg  <= hit_next;
            out_x_reg    <= hit_next ? sumx[W-1:0] : '0;
            out_y_reg    <= hit_next ? sumy[W-1:0] : '0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OW'({out_y_reg, out_x_reg});
    assign m_tuser  = {out_kind_reg, out_hit_reg};

endmodule

/* design/sip_checker.sv */
// Port-level checks for the segment intersection block, bound to its top level.
module sip_checker #(
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    input logic [2:0]                          m_tuser
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // The hit flag agrees with the kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] != sip_pkg::KIND_NONE)))
        else $error("hit flag disagrees with hit kind");

    // A miss carries a zero point.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("nonzero point on a miss");

    // The pipeline takes no input while a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during output stall");

endmodule

bind segment_intersection_point sip_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
